FILE: hdl/dgf_pkg.sv
// ---------------------------------------------------------------------------
// dgf_pkg
// shared types and constants of the elevation grid filler
// ---------------------------------------------------------------------------
`default_nettype none
package dgf_pkg;
    localparam int MAX_ROWS_DEF    = 1024;
    localparam int MAX_COLS_DEF    = 512;
    localparam int CELL_METRES_DEF = 5;
    localparam int Z_W   = 19;
    localparam int CRD_W = 20;
    localparam int HM_W  = 13;
    localparam int SUM_W = 23;

    localparam logic [2:0] REG_ROWS   = 3'd0;
    localparam logic [2:0] REG_COLS   = 3'd1;
    localparam logic [2:0] REG_ORG_N  = 3'd2;
    localparam logic [2:0] REG_ORG_E  = 3'd3;
    localparam logic [2:0] REG_THRESH = 3'd4;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIVN,
        ST_DIVE,
        ST_CLAMP,
        ST_NADDR,
        ST_NACC,
        ST_CMP,
        ST_WR,
        ST_RADDR,
        ST_RWAIT,
        ST_RDIV,
        ST_OUT
    } state_t;
endpackage
`default_nettype wire

FILE: hdl/dgf_grid_ram.sv
// ---------------------------------------------------------------------------
// dgf_grid_ram
// single-port grid memory with registered read data
// ---------------------------------------------------------------------------
`default_nettype none
module dgf_grid_ram #(
    parameter int AW = 19,
    parameter int DW = 19
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] addr,
    input  wire logic [DW-1:0] wdata,
    output logic      [DW-1:0] rdata
);
    logic [DW-1:0] mem [0:(1<<AW)-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

FILE: hdl/dem_grid_fill_outlier_reject_core.sv
// ---------------------------------------------------------------------------
// dem_grid_fill_outlier_reject_core
// elevation grid filler with neighbour-mean outlier rejection
// ---------------------------------------------------------------------------
// sequence: a write passes two reciprocal divides, clamp, nine neighbour slots on the single
//   memory port, a 4-step count multiply and one write before its result is offered; a read
//   passes address, read wait and divide by 100 before its result is offered
// flow: one word at a time; the next word is taken only after the last result is taken
// reset: after rst_n the grid is swept to zero, one address per cycle, all 524288 addresses at
//   the default size, with in_stall high; configuration writes are taken during the sweep
`default_nettype none
module dem_grid_fill_outlier_reject_core
    import dgf_pkg::*;
#(
    parameter int MAX_ROWS    = MAX_ROWS_DEF,
    parameter int MAX_COLS    = MAX_COLS_DEF,
    parameter int CELL_METRES = CELL_METRES_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic                operation,
    input  wire logic [CRD_W-1:0]    northing,
    input  wire logic [CRD_W-1:0]    easting,
    input  wire logic [Z_W-1:0]      elevation_cm,
    input  wire logic [9:0]          read_row,
    input  wire logic [8:0]          read_col,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [HM_W-1:0]          height_m,
    output logic                     stored,
    output logic                     clamped,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [31:0]         cfg_data
);
    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);
    localparam int AW = RW + CW;
    localparam int DEPTH = 1 << AW;
    localparam int CLW = $clog2(DEPTH + 1);

    // reciprocal constants: floor(x/d) = (x*ceil(2^k/d)) >> k for every 20-bit x
    localparam int CM_PER_M = 100;
    localparam int K_CELL   = CRD_W + $clog2(CELL_METRES);
    localparam int K_HUND   = CRD_W + $clog2(CM_PER_M);
    localparam int RCP_W    = CRD_W + 2;
    localparam int PROD_W   = CRD_W + RCP_W;
    localparam logic [RCP_W-1:0] RCP_CELL = RCP_W'(((longint'(1) << K_CELL)
        + longint'(CELL_METRES) - 1) / longint'(CELL_METRES));
    localparam logic [RCP_W-1:0] RCP_HUND = RCP_W'(((longint'(1) << K_HUND)
        + longint'(CM_PER_M) - 1) / longint'(CM_PER_M));

    // configuration registers
    logic [10:0]      rows_reg;
    logic [9:0]       cols_reg;
    logic [CRD_W-1:0] org_n_reg, org_e_reg;
    logic [Z_W-1:0]   thr_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= 11'd600;
            cols_reg  <= 10'd450;
            org_n_reg <= '0;
            org_e_reg <= '0;
            thr_reg   <= 19'd3000;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ROWS:   rows_reg  <= cfg_data[10:0];
                REG_COLS:   cols_reg  <= cfg_data[9:0];
                REG_ORG_N:  org_n_reg <= cfg_data[CRD_W-1:0];
                REG_ORG_E:  org_e_reg <= cfg_data[CRD_W-1:0];
                REG_THRESH: thr_reg   <= cfg_data[Z_W-1:0];
                default:    ;
            endcase
        end
    end

    // effective sizes, limited to 1..MAX
    logic [12:0] rows_eff, cols_eff;
    always_comb
    begin
        if (rows_reg == '0)
            rows_eff = 13'd1;
        else if (13'(rows_reg) > 13'(MAX_ROWS))
            rows_eff = 13'(MAX_ROWS);
        else
            rows_eff = 13'(rows_reg);
        if (cols_reg == '0)
            cols_eff = 13'd1;
        else if (13'(cols_reg) > 13'(MAX_COLS))
            cols_eff = 13'(MAX_COLS);
        else
            cols_eff = 13'(cols_reg);
    end

    // clearing sweep after reset
    logic [CLW-1:0] clr_reg;
    logic           clr_busy;
    assign clr_busy = (clr_reg != CLW'(DEPTH));
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (clr_busy)
            clr_reg <= clr_reg + 1'b1;
    end

    // sequencer state and datapath registers
    state_t state_reg, state_next;
    logic [CRD_W-1:0] dn_reg;      // northing offset, then column quotient / read value
    logic [CRD_W-1:0] de_reg;
    logic [CRD_W-1:0] qn_reg;
    logic             neg_n_reg, neg_e_reg;
    logic [RW-1:0]    row_reg;
    logic [CW-1:0]    col_reg;
    logic             clip_reg;
    logic [Z_W-1:0]   z_reg;
    logic [3:0]       nb_reg;      // neighbour index 0..8, centre skipped
    logic             rd_ok_reg;   // pending read is in grid
    logic [SUM_W-1:0] sum_reg;
    logic [3:0]       cnt_reg;
    logic [4:0]       step_reg;    // compare step
    logic [SUM_W+3:0] zc_reg, tc_reg;
    logic             keep_reg;
    logic [HM_W-1:0]  hm_reg;
    logic [AW-1:0]    addr_reg;

    // memory
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [Z_W-1:0] ram_wdata, ram_rdata;

    dgf_grid_ram #(.AW(AW), .DW(Z_W)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // neighbour offsets from nb index
    logic signed [1:0] dr, dc;
    logic signed [RW+1:0] ny;
    logic signed [CW+1:0] nx;
    logic          nb_in;
    always_comb
    begin
        dr = 2'sd0;
        dc = 2'sd0;
        case (nb_reg)
            4'd0: begin dr = -2'sd1; dc = -2'sd1; end
            4'd1: begin dr = -2'sd1; dc =  2'sd0; end
            4'd2: begin dr = -2'sd1; dc =  2'sd1; end
            4'd3: begin dr =  2'sd0; dc = -2'sd1; end
            4'd5: begin dr =  2'sd0; dc =  2'sd1; end
            4'd6: begin dr =  2'sd1; dc = -2'sd1; end
            4'd7: begin dr =  2'sd1; dc =  2'sd0; end
            4'd8: begin dr =  2'sd1; dc =  2'sd1; end
            default: ;
        endcase
        ny = $signed({2'b00, row_reg}) + (RW+2)'(dr);
        nx = $signed({2'b00, col_reg}) + (CW+2)'(dc);
        nb_in = (nb_reg != 4'd4) && (ny >= 0) && (nx >= 0)
              && (13'(ny[RW:0]) < rows_eff) && (13'(nx[CW:0]) < cols_eff);
    end

    // shared reciprocal multiplier: divide by the cell size or by 100
    logic [CRD_W-1:0]  div_a;
    logic [RCP_W-1:0]  div_m;
    logic [PROD_W-1:0] div_prod;
    logic [CRD_W-1:0]  div_q;
    always_comb
    begin
        div_a = (state_reg == ST_DIVE) ? de_reg : dn_reg;
        div_m = (state_reg == ST_RDIV) ? RCP_HUND : RCP_CELL;
        div_prod = PROD_W'(div_a) * PROD_W'(div_m);
        if (state_reg == ST_RDIV)
            div_q = CRD_W'(div_prod >> K_HUND);
        else
            div_q = CRD_W'(div_prod >> K_CELL);
    end

    // magnitude of zc - sum against thr*cnt
    logic [SUM_W+3:0] dev;
    logic             keep_now;
    assign dev = (zc_reg >= 27'(sum_reg)) ? zc_reg - 27'(sum_reg) : 27'(sum_reg) - zc_reg;
    assign keep_now = (cnt_reg == '0) || (dev <= tc_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid && !in_stall)
                    state_next = (operation == OP_READ) ? ST_RADDR : ST_DIVN;
            ST_DIVN:  state_next = ST_DIVE;
            ST_DIVE:  state_next = ST_CLAMP;
            ST_CLAMP: state_next = ST_NADDR;
            ST_NADDR: state_next = (nb_reg == 4'd8) ? ST_NACC : ST_NADDR;
            ST_NACC:  state_next = ST_CMP;
            ST_CMP:   if (step_reg == 5'd0) state_next = ST_WR;
            ST_WR:    state_next = ST_OUT;
            ST_RADDR: state_next = ST_RWAIT;
            ST_RWAIT: state_next = ST_RDIV;
            ST_RDIV:  state_next = ST_OUT;
            ST_OUT:   if (!out_stall) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE) || clr_busy;
        out_valid = (state_reg == ST_OUT);
        ram_we    = 1'b0;
        ram_addr  = addr_reg;
        ram_wdata = z_reg;
        if (clr_busy)
        begin
            ram_we    = 1'b1;
            ram_addr  = AW'(clr_reg);
            ram_wdata = '0;
        end
        else if (state_reg == ST_NADDR)
        begin
            ram_addr = {ny[RW-1:0], nx[CW-1:0]};
        end
        else if (state_reg == ST_WR)
        begin
            ram_we = keep_now;
        end
    end

    assign height_m = hm_reg;
    assign stored   = keep_reg;
    assign clamped  = clip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // read data arrives in the cycle after the address; track its validity
    logic acc_vld_reg;

    always_ff @(posedge clk)
    begin
        acc_vld_reg <= (state_reg == ST_NADDR) && nb_in;
        if (acc_vld_reg && (ram_rdata != '0))
        begin
            sum_reg <= sum_reg + SUM_W'(ram_rdata);
            cnt_reg <= cnt_reg + 1'b1;
        end
        case (state_reg)
            ST_IDLE:
            begin
                z_reg  <= elevation_cm;
                keep_reg <= 1'b0;
                clip_reg <= 1'b0;
                hm_reg   <= '0;
                neg_n_reg <= northing < org_n_reg;
                neg_e_reg <= easting < org_e_reg;
                dn_reg   <= northing - org_n_reg;
                de_reg   <= easting - org_e_reg;
                rd_ok_reg <= (13'(read_row) < rows_eff) && (13'(read_col) < cols_eff);
                addr_reg <= {RW'(rows_eff - 13'(read_row) - 13'd1), CW'(read_col)};
            end
            ST_DIVN:
            begin
                qn_reg <= div_q;
            end
            ST_DIVE:
            begin
                dn_reg <= div_q;
            end
            ST_RDIV:
            begin
                hm_reg <= rd_ok_reg ? HM_W'(div_q) : '0;
            end
            ST_CLAMP:
            begin
                // qn_reg: row quotient, dn_reg: column quotient
                if (neg_n_reg)
                    row_reg <= '0;
                else if (qn_reg >= CRD_W'(rows_eff))
                    row_reg <= RW'(rows_eff - 13'd1);
                else
                    row_reg <= RW'(qn_reg);
                if (neg_e_reg)
                    col_reg <= '0;
                else if (dn_reg >= CRD_W'(cols_eff))
                    col_reg <= CW'(cols_eff - 13'd1);
                else
                    col_reg <= CW'(dn_reg);
                clip_reg <= neg_n_reg || neg_e_reg || (qn_reg >= CRD_W'(rows_eff))
                          || (dn_reg >= CRD_W'(cols_eff));
                nb_reg  <= '0;
                sum_reg <= '0;
                cnt_reg <= '0;
            end
            ST_NADDR:
            begin
                nb_reg <= nb_reg + 1'b1;
            end
            ST_NACC:
            begin
                addr_reg <= {row_reg, col_reg};
                zc_reg   <= '0;
                tc_reg   <= '0;
                step_reg <= 5'd3;
            end
            ST_CMP:
            begin
                // shift-add multiply by the count, one bit a step
                if (cnt_reg[step_reg[1:0]])
                begin
                    zc_reg <= (zc_reg << 1) + 27'(z_reg);
                    tc_reg <= (tc_reg << 1) + 27'(thr_reg);
                end
                else
                begin
                    zc_reg <= zc_reg << 1;
                    tc_reg <= tc_reg << 1;
                end
                if (step_reg != 5'd0)
                    step_reg <= step_reg - 1'b1;
            end
            ST_WR:
            begin
                keep_reg <= keep_now;
            end
            ST_RWAIT:
            begin
                dn_reg <= CRD_W'(ram_rdata);
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

FILE: hdl/dgf_checker.sv
// ---------------------------------------------------------------------------
// dgf_checker
// port-level checks of the grid filler
// ---------------------------------------------------------------------------
`default_nettype none
module dgf_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_stall,
    input wire logic out_valid,
    input wire logic out_stall,
    input wire logic stored,
    input wire logic clamped,
    input wire logic [12:0] height_m
);
    // a new word is never taken while a result waits
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("accept while result pending");

    // one word at a time: input stalls right after a word is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall) else $error("second word taken while busy");

    // result waits while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(stored) && $stable(height_m))
        else $error("result dropped under stall");

    // write results carry no height
    a_write_no_height: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (stored || clamped) |-> height_m == '0)
        else $error("height on write result");
endmodule

bind dem_grid_fill_outlier_reject_core dgf_checker u_dgf_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .stored(stored),
    .clamped(clamped), .height_m(height_m)
);
`default_nettype wire

FILE: tb/sv/dem_grid_fill_outlier_reject_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dem_grid_fill_outlier_reject_core_tb
// self-checking bench for the elevation grid filler: a local grid model
// predicts the result of each accepted word and a monitor compares fields
// ---------------------------------------------------------------------------
`default_nettype none
module dem_grid_fill_outlier_reject_core_tb;
    import dgf_pkg::*;

    localparam int NROWS      = MAX_ROWS_DEF;
    localparam int NCOLS      = MAX_COLS_DEF;
    localparam int CELL       = CELL_METRES_DEF;
    localparam int IDLE_LIMIT = 4 * NROWS * NCOLS;

    // one expected result word
    typedef struct packed {
        logic [HM_W-1:0] height_m;
        logic            stored;
        logic            clamped;
    } grid_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic operation = OP_WRITE;
    logic [CRD_W-1:0] northing = '0;
    logic [CRD_W-1:0] easting = '0;
    logic [Z_W-1:0] elevation_cm = '0;
    logic [9:0] read_row = '0;
    logic [8:0] read_col = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [HM_W-1:0] height_m;
    logic stored;
    logic clamped;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // model state: grid and registers
    logic [Z_W-1:0] grid_model [NROWS*NCOLS];
    logic [10:0] m_rows;
    logic [9:0] m_cols;
    logic [19:0] m_org_n;
    logic [19:0] m_org_e;
    logic [18:0] m_thresh;

    grid_result_t pending_results[$];
    int errors = 0;
    int checked = 0;
    int writes_sent = 0;
    int reads_sent = 0;
    int idle_cycles = 0;
    int stall_run = 0;
    bit hold_off = 1'b0;
    bit quiet_out = 1'b0;

    always #10 clk = ~clk;

    dem_grid_fill_outlier_reject_core dut (.*);

    // watchdog: cycles with no word or register moving
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    endtask

    // output side: random stall, occasional long run, long hold-off on request
    always @(posedge clk)
    begin
        if (stall_run > 0)
        begin
            stall_run <= stall_run - 1;
            out_stall <= 1'b1;
        end
        else if (hold_off || (!quiet_out && $urandom_range(0, 99) < 25))
            out_stall <= 1'b1;
        else if (!quiet_out && $urandom_range(0, 99) < 2)
        begin
            stall_run <= $urandom_range(20, 80);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // result monitor
    always @(posedge clk)
    begin
        grid_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected word", 1, 0);
            else
            begin
                want = pending_results.pop_front();
                checked++;
                if (height_m !== want.height_m)
                    report_mismatch("height_m", height_m, want.height_m);
                if (stored !== want.stored)
                    report_mismatch("stored", stored, want.stored);
                if (clamped !== want.clamped)
                    report_mismatch("clamped", clamped, want.clamped);
            end
        end
    end

    function automatic int eff_rows();
        if (m_rows < 1) return 1;
        if (m_rows > NROWS) return NROWS;
        return m_rows;
    endfunction

    function automatic int eff_cols();
        if (m_cols < 1) return 1;
        if (m_cols > NCOLS) return NCOLS;
        return m_cols;
    endfunction

    // coordinate to cell index, clamped
    function automatic int cell_of(input longint coord, input longint org, input int lim,
                                   inout bit clip);
        longint idx;
        if (coord < org)
        begin
            clip = 1'b1;
            return 0;
        end
        idx = (coord - org) / CELL;
        if (idx >= lim)
        begin
            clip = 1'b1;
            return lim - 1;
        end
        return int'(idx);
    endfunction

    // predict the word for one item and update the grid
    function automatic grid_result_t predict_fill(input logic op, input logic [19:0] n,
        input logic [19:0] e, input logic [18:0] z, input logic [9:0] rr, input logic [8:0] rc);
        grid_result_t r;
        int rows, cols, row, col, y, x;
        bit clip;
        longint sum, cnt, zc, dev;
        bit keep;
        r = '0;
        rows = eff_rows();
        cols = eff_cols();
        clip = 1'b0;
        sum = 0;
        cnt = 0;
        if (op == OP_READ)
        begin
            if (rr < rows && rc < cols)
                r.height_m = HM_W'(grid_model[(rows - rr - 1) * NCOLS + rc] / 100);
            return r;
        end
        row = cell_of(n, m_org_n, rows, clip);
        col = cell_of(e, m_org_e, cols, clip);
        for (int dr = -1; dr <= 1; dr++)
            for (int dc = -1; dc <= 1; dc++)
            begin
                y = row + dr;
                x = col + dc;
                if ((dr != 0 || dc != 0) && y >= 0 && y < rows && x >= 0 && x < cols
                    && grid_model[y * NCOLS + x] > 0)
                begin
                    sum += grid_model[y * NCOLS + x];
                    cnt++;
                end
            end
        if (cnt == 0)
            keep = 1'b1;
        else
        begin
            zc = longint'(z) * cnt;
            dev = (zc >= sum) ? zc - sum : sum - zc;
            keep = dev <= longint'(m_thresh) * cnt;
        end
        if (keep)
            grid_model[row * NCOLS + col] = z;
        r.stored = keep;
        r.clamped = clip;
        return r;
    endfunction

    // wait until the block has drained, then write one register
    task automatic write_reg(input logic [2:0] idx, input int unsigned val);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_ROWS:   m_rows = val[10:0];
            REG_COLS:   m_cols = val[9:0];
            REG_ORG_N:  m_org_n = val[19:0];
            REG_ORG_E:  m_org_e = val[19:0];
            REG_THRESH: m_thresh = val[18:0];
            default: ;
        endcase
    endtask

    // send one word; gap first so idling falls on all phases of the work
    task automatic send_word(input logic op, input logic [19:0] n, input logic [19:0] e,
        input logic [18:0] z, input logic [9:0] rr, input logic [8:0] rc, input bit gaps = 1);
        int gap;
        gap = 1;
        if (gaps && $urandom_range(0, 3) == 0)
            gap = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 4);
        repeat (gap) @(posedge clk);
        in_valid <= 1'b1;
        operation <= op;
        northing <= n;
        easting <= e;
        elevation_cm <= z;
        read_row <= rr;
        read_col <= rc;
        do @(posedge clk); while (in_stall);
        pending_results.push_back(predict_fill(op, n, e, z, rr, rc));
        if (op == OP_READ) reads_sent++; else writes_sent++;
        in_valid <= 1'b0;
    endtask

    task automatic write_point(input int n, input int e, input int z, input bit gaps = 1);
        send_word(OP_WRITE, 20'(n), 20'(e), 19'(z), 10'($urandom), 9'($urandom), gaps);
    endtask

    task automatic read_cell(input int rr, input int rc);
        send_word(OP_READ, 20'($urandom), 20'($urandom), 19'($urandom), 10'(rr), 9'(rc));
    endtask

    // small grid, extremes of coordinates and elevation, reads outside the grid
    task automatic test_directed();
        write_reg(REG_ROWS, 8);
        write_reg(REG_COLS, 6);
        write_reg(REG_ORG_N, 100);
        write_reg(REG_ORG_E, 200);
        write_reg(REG_THRESH, 3000);
        write_point(110, 210, 50000);          // empty neighbourhood, stored
        write_point(115, 210, 51000);          // close to mean, stored
        write_point(110, 215, 90000);          // outlier, rejected
        write_point(0, 0, 40000);              // south-west of origin
        write_point(20'hFFFFF, 20'hFFFFF, 19'h7FFFF); // past grid end
        write_point(100, 200, 0);              // zero elevation
        write_point(100 + 5 * 7, 200 + 5 * 5, 1);
        write_point(100 + 5 * 7 + 4, 200 + 5 * 5 + 4, 19'h7FFFF);
        read_cell(0, 0);
        read_cell(7, 0);
        read_cell(5, 2);
        read_cell(0, 5);
        read_cell(8, 0);                       // outside rows
        read_cell(0, 6);                       // outside cols
        read_cell(10'h3FF, 9'h1FF);
        write_reg(REG_THRESH, 0);
        write_point(125, 215, 50000);
        write_point(125, 220, 50000);
        read_cell(4, 3);
    endtask

    // out-of-range size registers and largest sizes
    task automatic test_size_limits();
        write_reg(REG_ROWS, 0);
        write_reg(REG_COLS, 0);
        write_point(0, 0, 1234);
        write_point(20'hFFFFF, 20'hFFFFF, 2000);
        read_cell(0, 0);
        write_reg(REG_ROWS, 11'h7FF);
        write_reg(REG_COLS, 10'h3FF);
        write_reg(REG_ORG_N, 0);
        write_reg(REG_ORG_E, 0);
        write_point(20'hFFFFF, 20'hFFFFF, 7777);
        write_point(20'hFFFFF, 20'hFFFFF - 5, 7700);
        read_cell(0, 511);
        read_cell(1023, 0);
        read_cell(10'h3FF, 9'h1FF);
    endtask

    // random clustered survey on a small grid plus noise
    task automatic test_random(input int count, input int rows, input int cols,
                               input int unsigned thr);
        int base_z;
        write_reg(REG_ROWS, rows);
        write_reg(REG_COLS, cols);
        write_reg(REG_ORG_N, $urandom_range(0, 5000));
        write_reg(REG_ORG_E, $urandom_range(0, 5000));
        write_reg(REG_THRESH, thr);
        base_z = $urandom_range(1000, 400000);
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 9))
                0: send_word(1'($urandom), 20'($urandom), 20'($urandom), 19'($urandom),
                             10'($urandom), 9'($urandom));
                1, 2, 3:
                    read_cell($urandom_range(0, rows + 1), $urandom_range(0, cols + 1));
                default:
                    write_point(m_org_n + $urandom_range(0, CELL * rows + 8) - 4,
                                m_org_e + $urandom_range(0, CELL * cols + 8) - 4,
                                ($urandom_range(0, 4) == 0) ? $urandom_range(0, 19'h7FFFF)
                                : base_z + $urandom_range(0, 8000) - 4000);
            endcase
        end
    endtask

    // output held off while writes keep coming so the block backs up
    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 8; i++)
                write_point(m_org_n + $urandom_range(0, 30), m_org_e + $urandom_range(0, 30),
                            $urandom_range(1, 19'h7FFFF), 0);
        join
        // sender pauses until everything has come back
        while (pending_results.size() != 0) @(posedge clk);
        quiet_out = 1'b1;
        for (int i = 0; i < 20; i++)
            read_cell($urandom_range(0, 10), $urandom_range(0, 10));
        quiet_out = 1'b0;
    endtask

    initial
    begin
        for (int i = 0; i < NROWS * NCOLS; i++) grid_model[i] = '0;
        m_rows = 600;
        m_cols = 450;
        m_org_n = 0;
        m_org_e = 0;
        m_thresh = 3000;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        read_cell(0, 0);          // default configuration before any write
        write_point(12, 13, 4321);
        read_cell(597, 2);
        test_directed();
        test_size_limits();
        test_random(200, 6, 5, 3000);
        test_backpressure();
        test_random(200, 10, 12, $urandom_range(0, 20000));
        test_random(180, 4, 3, 19'h7FFFF);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        $display("covered %0d writes and %0d reads, %0d words checked",
                 writes_sent, reads_sent, checked);
        $display("size, origin and threshold registers swept incl. extremes and clamping");
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire
